// ===== sv/lfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder package
// Shared types and constants of the LED frame stream decoder.
// ----------------------------------------------------------------------------
package lfsd_pkg;

   typedef enum logic [1:0] {
      MODE_RGB24       = 2'd0,
      MODE_RGB565_RUN  = 2'd1,
      MODE_INDEXED     = 2'd2,
      MODE_INDEXED_RUN = 2'd3
   } mode_type;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT = 1'b1;

   localparam logic [7:0] LEN_MASK    = 8'h7F;
   localparam logic [7:0] RED_MASK    = 8'hF8;
   localparam logic [7:0] GRN_HI_MASK = 8'h07;
   localparam logic [7:0] GRN_LO_MASK = 8'hE0;
   localparam logic [7:0] BLU_MASK    = 8'h1F;

   localparam logic [1:0] COMP_RED   = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE  = 2'd2;

   // Work handed from the parser to the run emitter for one transaction.
   typedef struct packed {
      logic        clear;
      logic        emit;
      logic [7:0]  len;
      logic        use_pal;
      logic        black;
      logic [23:0] rgb;
   } item_type;

   // One colour component written into the palette.
   typedef struct packed {
      logic       we;
      logic [1:0] comp;
      logic [7:0] entry;
      logic [7:0] data;
   } pal_wr_type;

endpackage

// ===== sv/lfsd_palette.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder palette
// Palette memory with per-component writes and a registered read port.
// ----------------------------------------------------------------------------
module lfsd_palette #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  lfsd_pkg::pal_wr_type wr,
   input  logic                rd_en,
   input  logic [7:0]          rd_addr,
   output logic [23:0]         rd_data
);
   import lfsd_pkg::*;

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [23:0]   mem [PALETTE_DEPTH];
   logic [23:0]   rd_data_ff;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_w;

   assign wr_addr   = wr.entry[AW-1:0];
   assign rd_addr_w = rd_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         case (wr.comp)
            COMP_RED:   mem[wr_addr][23:16] <= wr.data;
            COMP_GREEN: mem[wr_addr][15:8]  <= wr.data;
            default:    mem[wr_addr][7:0]   <= wr.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_w];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lfsd_parser.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder parser
// Byte parser: palette header loading and pixel code assembly per mode.
// ----------------------------------------------------------------------------
module lfsd_parser #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  start_of_stream,
   input  lfsd_pkg::mode_type    mode,
   output lfsd_pkg::item_type    item,
   output lfsd_pkg::pal_wr_type  pal_wr
);
   import lfsd_pkg::*;

   localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

   logic [7:0]  size_ff,  size_in,  size_e;
   logic [9:0]  load_ff,  load_in,  load_e;
   logic        hd_ff,    hd_in,    hd_e;
   logic [1:0]  phase_ff, phase_in, phase_e;
   logic [15:0] held_ff,  held_in,  held_e;
   logic [7:0]  entry_ff, entry_in, entry_e;
   logic [1:0]  comp_ff,  comp_in,  comp_e;
   logic [9:0]  triple_bytes;
   logic [7:0]  hi;
   logic [7:0]  lo;

   always_comb begin
      size_e  = start_of_stream ? 8'd0  : size_ff;
      load_e  = start_of_stream ? 10'd0 : load_ff;
      hd_e    = start_of_stream ? 1'b0  : hd_ff;
      phase_e = start_of_stream ? 2'd0  : phase_ff;
      held_e  = start_of_stream ? 16'd0 : held_ff;
      entry_e = start_of_stream ? 8'd0  : entry_ff;
      comp_e  = start_of_stream ? COMP_RED : comp_ff;
   end

   assign triple_bytes = {1'b0, size_e, 1'b0} + {2'b00, size_e};
   assign hi = held_e[15:8];
   assign lo = data_byte;

   always_comb begin
      size_in  = size_e;
      load_in  = load_e;
      hd_in    = hd_e;
      phase_in = phase_e;
      held_in  = held_e;
      entry_in = entry_e;
      comp_in  = comp_e;

      item.clear   = start_of_stream;
      item.emit    = 1'b0;
      item.len     = 8'd1;
      item.use_pal = 1'b0;
      item.black   = ({1'b0, data_byte} >= DEPTH_W) || (data_byte >= size_e);
      item.rgb     = 24'd0;

      pal_wr.we    = 1'b0;
      pal_wr.comp  = comp_e;
      pal_wr.entry = entry_e;
      pal_wr.data  = data_byte;

      if (mode[1] && !hd_e) begin
         if (load_e == 10'd0) begin
            size_in = data_byte;
            load_in = 10'd1;
            hd_in   = (data_byte == 8'd0);
         end else begin
            pal_wr.we = ({1'b0, entry_e} < DEPTH_W);
            if (comp_e == COMP_BLUE) begin
               comp_in  = COMP_RED;
               entry_in = entry_e + 8'd1;
            end else begin
               comp_in = comp_e + 2'd1;
            end
            load_in = load_e + 10'd1;
            if (load_e >= triple_bytes) begin
               hd_in = 1'b1;
            end
         end
      end else begin
         unique case (mode)
            MODE_RGB24, MODE_RGB565_RUN: begin
               if (phase_e == 2'd0) begin
                  held_in  = (mode == MODE_RGB24) ? {8'd0, data_byte}
                                                  : {8'd0, data_byte & LEN_MASK};
                  phase_in = 2'd1;
               end else if (phase_e == 2'd1) begin
                  held_in  = {data_byte, held_e[7:0]};
                  phase_in = 2'd2;
               end else begin
                  phase_in  = 2'd0;
                  item.emit = 1'b1;
                  if (mode == MODE_RGB24) begin
                     item.rgb = {held_e[7:0], held_e[15:8], data_byte};
                  end else begin
                     item.len = held_e[7:0] & LEN_MASK;
                     item.rgb = {hi & RED_MASK,
                                 (hi & GRN_HI_MASK) << 5 | (lo & GRN_LO_MASK) >> 3,
                                 (lo & BLU_MASK) << 3};
                  end
               end
            end
            MODE_INDEXED: begin
               phase_in     = 2'd0;
               item.emit    = 1'b1;
               item.use_pal = 1'b1;
            end
            MODE_INDEXED_RUN: begin
               if (phase_e == 2'd0) begin
                  held_in  = {8'd0, data_byte};
                  phase_in = 2'd1;
               end else begin
                  phase_in     = 2'd0;
                  item.emit    = 1'b1;
                  item.use_pal = 1'b1;
                  item.len     = held_e[7:0];
               end
            end
         endcase
      end

      if (!accept) begin
         pal_wr.we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 8'd0;
         load_ff  <= 10'd0;
         hd_ff    <= 1'b0;
         phase_ff <= 2'd0;
         held_ff  <= 16'd0;
         entry_ff <= 8'd0;
         comp_ff  <= COMP_RED;
      end else if (accept) begin
         size_ff  <= size_in;
         load_ff  <= load_in;
         hd_ff    <= hd_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         entry_ff <= entry_in;
         comp_ff  <= comp_in;
      end
   end

endmodule

// ===== sv/lfsd_emitter.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder run emitter
// Holds one parsed transaction, places the run in the frame and drives the
// result register.
// ----------------------------------------------------------------------------
module lfsd_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  lfsd_pkg::item_type item,
   input  logic [23:0]        pal_data,
   input  logic [7:0]         led_count,
   output logic               in_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [7:0]         rsp_first_led,
   output logic [7:0]         rsp_led_span,
   output logic               rsp_frame_done
);
   import lfsd_pkg::*;

   logic        s1_valid_ff;
   item_type    s1_item_ff;
   logic        produces;
   logic        out_free;
   logic        s1_move;
   logic [7:0]  frame;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  start_pos;
   logic [7:0]  rem;
   logic [7:0]  n;
   logic [8:0]  end_pos;
   logic        done;
   logic [23:0] color;

   logic        rsp_valid_ff;
   logic [23:0] color_ff;
   logic [7:0]  first_ff;
   logic [7:0]  len_ff;
   logic        done_ff;

   assign produces = s1_item_ff.emit && (s1_item_ff.len != 8'd0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_move  = s1_valid_ff && (!produces || out_free);
   assign in_ready = !s1_valid_ff || s1_move;

   always_comb begin
      frame     = (led_count == 8'd0) ? 8'd1 : led_count;
      start_pos = s1_item_ff.clear ? 8'd0 : pos_ff;
      if (start_pos >= frame) begin
         start_pos = 8'd0;
      end
      rem     = frame - start_pos;
      n       = (s1_item_ff.len < rem) ? s1_item_ff.len : rem;
      end_pos = {1'b0, start_pos} + {1'b0, n};
      done    = (end_pos >= {1'b0, frame});
      if (!produces) begin
         pos_in = s1_item_ff.clear ? 8'd0 : pos_ff;
      end else if (done) begin
         pos_in = 8'd0;
      end else begin
         pos_in = end_pos[7:0];
      end
      if (!s1_item_ff.use_pal) begin
         color = s1_item_ff.rgb;
      end else if (s1_item_ff.black) begin
         color = 24'd0;
      end else begin
         color = pal_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
      end else if (s1_move) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && produces) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && produces) begin
         color_ff <= color;
         first_ff <= start_pos;
         len_ff   <= n;
         done_ff  <= done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = color_ff[23:16];
   assign rsp_green      = color_ff[15:8];
   assign rsp_blue       = color_ff[7:0];
   assign rsp_first_led  = first_ff;
   assign rsp_led_span   = len_ff;
   assign rsp_frame_done = done_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (len_ff != 8'd0))
      else $error("run of zero length presented");

   a_run_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (({1'b0, first_ff} + {1'b0, len_ff}) <= {1'b0, frame}))
      else $error("run extends past the frame end");

   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (done_ff == (({1'b0, first_ff} + {1'b0, len_ff}) == {1'b0, frame})))
      else $error("frame done flag does not match the run end");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (s1_move && produces) |=> (pos_ff < frame))
      else $error("frame position left outside the frame after a run");

endmodule

// ===== sv/led_frame_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder
// Parses an LED animation byte stream (raw RGB24, RGB565 runs, indexed or
// indexed runs with a palette header) and emits coloured pixel runs.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    data_byte, start_of_stream
//   rsp_     out        rsp_valid/rsp_ready    red, green, blue, first_led,
//                                              led_span, frame_done
//   csr_     in         csr_write_enable       csr_index, csr_write_data
//
// One transaction is accepted per cycle while the input is not stalled. A run
// passes from the parser through the emitter stage into the result register:
// the parser and the registered palette read complete at the accepting edge,
// and the emitter stage then places the run in the frame.
// Reset clears the parser, the frame position and both pipeline stages; the
// palette holds no reset and needs no clearing pass. A stalled result holds
// the emitter stage, and the input stalls only when that stage is full too.
// ----------------------------------------------------------------------------
module led_frame_stream_decoder #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_start_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_blue,
   output logic [7:0]                     rsp_first_led,
   output logic [7:0]                     rsp_led_span,
   output logic                           rsp_frame_done,
   input  logic                           csr_write_enable,
   input  logic [lfsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfsd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import lfsd_pkg::*;

   mode_type   mode_ff;
   logic [7:0] led_count_ff;
   logic       accept;
   item_type   item;
   pal_wr_type pal_wr;
   logic [23:0] pal_data;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RGB24;
         led_count_ff <= 8'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:      mode_ff      <= mode_type'(csr_write_data[1:0]);
            CSR_LED_COUNT: led_count_ff <= csr_write_data[7:0];
         endcase
      end
   end

   lfsd_parser #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .start_of_stream (req_start_of_stream),
      .mode            (mode_ff),
      .item            (item),
      .pal_wr          (pal_wr)
   );

   lfsd_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd_en   (accept),
      .rd_addr (req_data_byte),
      .rd_data (pal_data)
   );

   lfsd_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .item           (item),
      .pal_data       (pal_data),
      .led_count      (led_count_ff),
      .in_ready       (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_first_led  (rsp_first_led),
      .rsp_led_span   (rsp_led_span),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

// ===== test/led_frame_stream_checker.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder checker
// Watches the request, response and register ports of the decoder, keeps its
// own model of the parser, palette and frame position, and compares every
// response transaction field by field with the oldest predicted pixel run.
// ----------------------------------------------------------------------------
module led_frame_stream_checker #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_start_of_stream,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_red,
   input  logic [7:0]                       rsp_green,
   input  logic [7:0]                       rsp_blue,
   input  logic [7:0]                       rsp_first_led,
   input  logic [7:0]                       rsp_led_span,
   input  logic                             rsp_frame_done,
   input  logic                             csr_write_enable,
   input  logic [lfsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfsd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               fail_count,
   output int                               runs_pending
);
   import lfsd_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] first_led;
      logic [7:0] led_span;
      logic       frame_done;
   } pixel_run_type;

   pixel_run_type expected_runs[$];

   mode_type      cur_mode;
   logic [7:0]    frame_leds;
   logic [23:0]   palette [PALETTE_DEPTH];
   logic [7:0]    pal_size;
   logic [9:0]    load_index;
   logic          header_done;
   logic [1:0]    byte_phase;
   logic [15:0]   held_bytes;
   int unsigned   led_pos;

   task automatic clear_parser();
      pal_size    = 8'd0;
      load_index  = 10'd0;
      header_done = 1'b0;
      byte_phase  = 2'd0;
      held_bytes  = 16'd0;
      led_pos     = 0;
   endtask

   function automatic logic [23:0] palette_colour(input logic [7:0] idx);
      if (idx >= pal_size || idx >= PALETTE_DEPTH) begin
         return 24'h000000;
      end
      return palette[idx];
   endfunction

   task automatic place_run(input logic [23:0] rgb, input logic [7:0] len);
      pixel_run_type run;
      int unsigned   frame;
      int unsigned   room;
      int unsigned   n;
      frame = (frame_leds == 8'd0) ? 1 : frame_leds;
      if (len == 8'd0) begin
         return;
      end
      if (led_pos >= frame) begin
         led_pos = 0;
      end
      room = frame - led_pos;
      n = (len < room) ? len : room;
      run.red        = rgb[23:16];
      run.green      = rgb[15:8];
      run.blue       = rgb[7:0];
      run.first_led  = led_pos[7:0];
      run.led_span   = n[7:0];
      led_pos = led_pos + n;
      run.frame_done = (led_pos >= frame);
      if (run.frame_done) begin
         led_pos = 0;
      end
      expected_runs.push_back(run);
   endtask

   task automatic decode_stream_byte(input logic [7:0] b, input logic sos);
      int unsigned pos;
      int unsigned entry;
      logic [7:0]  hi;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  bl;
      if (sos) begin
         clear_parser();
      end
      if ((cur_mode == MODE_INDEXED || cur_mode == MODE_INDEXED_RUN) && !header_done) begin
         if (load_index == 10'd0) begin
            pal_size   = b;
            load_index = 10'd1;
            header_done = (b == 8'd0);
         end else begin
            pos   = load_index - 1;
            entry = pos / 3;
            if (entry < PALETTE_DEPTH) begin
               case (2'(pos % 3))
                  COMP_RED:   palette[entry][23:16] = b;
                  COMP_GREEN: palette[entry][15:8]  = b;
                  COMP_BLUE:  palette[entry][7:0]   = b;
                  default: ;
               endcase
            end
            load_index = load_index + 10'd1;
            if (pos + 1 >= 3 * pal_size) begin
               header_done = 1'b1;
            end
         end
         return;
      end
      case (cur_mode)
         MODE_RGB24, MODE_RGB565_RUN: begin
            if (byte_phase == 2'd0) begin
               held_bytes = {8'h00, (cur_mode == MODE_RGB24) ? b : (b & LEN_MASK)};
               byte_phase = 2'd1;
            end else if (byte_phase == 2'd1) begin
               held_bytes[15:8] = b;
               byte_phase = 2'd2;
            end else begin
               byte_phase = 2'd0;
               if (cur_mode == MODE_RGB24) begin
                  place_run({held_bytes[7:0], held_bytes[15:8], b}, 8'd1);
               end else begin
                  hi = held_bytes[15:8];
                  r  = hi & RED_MASK;
                  g  = ((hi & GRN_HI_MASK) << 5) | ((b & GRN_LO_MASK) >> 3);
                  bl = (b & BLU_MASK) << 3;
                  place_run({r, g, bl}, held_bytes[7:0] & LEN_MASK);
               end
            end
         end
         MODE_INDEXED: begin
            byte_phase = 2'd0;
            place_run(palette_colour(b), 8'd1);
         end
         default: begin
            if (byte_phase == 2'd0) begin
               held_bytes = {8'h00, b};
               byte_phase = 2'd1;
            end else begin
               byte_phase = 2'd0;
               place_run(palette_colour(b), held_bytes[7:0]);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      pixel_run_type want;
      if (reset) begin
         clear_parser();
         cur_mode   = MODE_RGB24;
         frame_leds = 8'd1;
         for (int i = 0; i < PALETTE_DEPTH; i++) begin
            palette[i] = 24'h000000;
         end
         expected_runs.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_MODE) begin
               cur_mode = mode_type'(csr_write_data[1:0]);
            end else if (csr_index == CSR_LED_COUNT) begin
               frame_leds = csr_write_data[7:0];
            end
         end
         if (req_valid && req_ready) begin
            decode_stream_byte(req_data_byte, req_start_of_stream);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_runs.size() == 0) begin
               $error("run at LED %0d of length %0d arrived with none predicted",
                      rsp_first_led, rsp_led_span);
               fail_count = fail_count + 1;
            end else begin
               want = expected_runs.pop_front();
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("first_led", want.first_led, rsp_first_led);
               check_field("led_span", want.led_span, rsp_led_span);
               check_field("frame_done", {7'd0, want.frame_done}, {7'd0, rsp_frame_done});
            end
         end
      end
      runs_pending = expected_runs.size();
   end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// LED frame stream decoder testbench
// Drives directed and random animation streams in all four modes through the
// decoder, with random gaps on both channels and register changes between
// phases, and reports the verdict of the run checker.
// ----------------------------------------------------------------------------
module tb;
   import lfsd_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic                   req_start_of_stream;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_red;
   logic [7:0]             rsp_green;
   logic [7:0]             rsp_blue;
   logic [7:0]             rsp_first_led;
   logic [7:0]             rsp_led_span;
   logic                   rsp_frame_done;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int   fail_count;
   int   runs_pending;
   int   cycle_count = 0;
   int   items_sent;
   int   pal_entries;
   int   big_headers;
   logic req_idle;
   logic rsp_idle;

   led_frame_stream_decoder DUT (.*);

   led_frame_stream_checker run_check (.*);

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            @(negedge clock);
            gap = rsp_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic sos);
      int gap;
      gap = req_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data_byte       <= b;
      req_start_of_stream <= sos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   // The decoder may still be working on a transaction that produces no run.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (runs_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input mode_type mode, input logic [7:0] leds);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MODE;
      csr_write_data   <= CSR_DATA_W'(mode);
      @(negedge clock);
      csr_index        <= CSR_LED_COUNT;
      csr_write_data   <= leds;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] pick_index();
      if (pal_entries > 0 && $urandom_range(0, 7) != 0) begin
         return 8'($urandom_range(0, pal_entries - 1));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_length();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return {1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))};
   endfunction

   initial begin
      mode_type   mode;
      logic [7:0] leds;
      logic       sos;
      int         codes;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_data_byte       = 8'h00;
      req_start_of_stream = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_MODE;
      csr_write_data      = '0;
      items_sent          = 0;
      pal_entries         = 0;
      big_headers         = 0;
      req_idle            = 1'b1;
      rsp_idle            = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A frame length of zero behaves as a single LED.
      wait_idle();
      set_config(MODE_RGB24, 8'd0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);

      // A zero run is dropped and a long run is cut at the frame end.
      wait_idle();
      set_config(MODE_RGB565_RUN, 8'd200);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);

      // Indices beyond the loaded palette give black.
      wait_idle();
      set_config(MODE_INDEXED, 8'd10);
      send_byte(8'h01, 1'b1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      pal_entries = 1;

      // The frame shrinks below the current position, so the next run restarts.
      wait_idle();
      set_config(MODE_INDEXED_RUN, 8'd2);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         mode = mode_type'(2'($urandom_range(0, 3)));
         case ($urandom_range(0, 5))
            0:       leds = 8'd1;
            1:       leds = 8'd255;
            2, 3:    leds = 8'($urandom_range(1, 16));
            default: leds = 8'($urandom_range(1, 255));
         endcase
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         wait_idle();
         set_config(mode, leds);
         if ($urandom_range(0, 7) != 0) begin
            sos = ($urandom_range(0, 3) != 0);
            if (sos && (mode == MODE_INDEXED || mode == MODE_INDEXED_RUN)) begin
               case ($urandom_range(0, 15))
                  0: pal_entries = 0;
                  1: begin
                     pal_entries = (big_headers < 2) ? 255 : 3;
                     big_headers = big_headers + 1;
                  end
                  default: pal_entries = $urandom_range(1, 12);
               endcase
               send_byte(8'(pal_entries), 1'b1);
               repeat (3 * pal_entries) send_byte(8'($urandom_range(0, 255)), 1'b0);
               sos = 1'b0;
            end
            codes = $urandom_range(4, 30);
            repeat (codes) begin
               case (mode)
                  MODE_RGB24: begin
                     send_byte(8'($urandom_range(0, 255)), sos);
                     send_byte(8'($urandom_range(0, 255)), 1'b0);
                     send_byte(8'($urandom_range(0, 255)), 1'b0);
                  end
                  MODE_RGB565_RUN: begin
                     send_byte(pick_length(), sos);
                     send_byte(8'($urandom_range(0, 255)), 1'b0);
                     send_byte(8'($urandom_range(0, 255)), 1'b0);
                  end
                  MODE_INDEXED: begin
                     send_byte(pick_index(), sos);
                  end
                  default: begin
                     send_byte(pick_length(), sos);
                     send_byte(pick_index(), 1'b0);
                  end
               endcase
               sos = 1'b0;
            end
         end else begin
            repeat ($urandom_range(1, 20)) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
